// ===== src/video_memory_access_port_core_defines.svh =====
// ----------------------------------------------------------------------------
// video_memory_access_port_core_defines
// assertion macros used by the checker file vmap_checker
// ----------------------------------------------------------------------------
`ifndef VIDEO_MEMORY_ACCESS_PORT_CORE_DEFINES_SVH
`define VIDEO_MEMORY_ACCESS_PORT_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define VMAP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define VMAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/vmap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmap_pkg
// types, codes and address folding for the video memory access port
// ----------------------------------------------------------------------------
package vmap_pkg;

  localparam int VMAP_MEM_DEPTH = 16384;

  localparam logic [2:0] REQ_ADDR   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_SCROLL = 3'd3;
  localparam logic [2:0] REQ_STATUS = 3'd4;

  localparam logic [1:0] MIRROR_HORZ = 2'd0;
  localparam logic [1:0] MIRROR_VERT = 2'd1;

  localparam logic [1:0] CFG_MIRROR_MODE = 2'd0;
  localparam logic [1:0] CFG_ADDR_INC_32 = 2'd1;

  localparam logic [15:0] UNMAPPED_BASE = 16'h4000;
  localparam logic [15:0] PAL_BASE      = 16'h3F00;
  localparam logic [15:0] PAL_MASK      = 16'h001F;
  localparam logic [15:0] BUFFERED_TOP  = 16'h3EFF;
  localparam logic [15:0] FOLD_HORZ     = 16'h0400;
  localparam logic [15:0] FOLD_VERT     = 16'h0800;
  localparam logic [7:0]  FINE_MASK     = 8'h07;
  localparam logic [7:0]  PAL_DATA_MASK = 8'h3F;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_in;
  } vmap_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        unmapped_error;
    logic [15:0] cur_address;
    logic [2:0]  scroll_fine_x;
    logic [4:0]  scroll_coarse_x;
    logic [2:0]  scroll_fine_y;
    logic [4:0]  scroll_coarse_y;
  } vmap_rsp_t;

  typedef struct packed {
    logic we;
    logic re;
  } vmap_mem_ctl_t;

  function automatic logic [15:0] vmap_fold(input logic [15:0] a, input logic [1:0] mode);
    logic [15:0] f;
    f = a;
    if (mode == MIRROR_HORZ) begin
      if (a inside {[16'h2400:16'h27FF], [16'h2C00:16'h2FFF]}) f = a - FOLD_HORZ;
    end else if (mode == MIRROR_VERT) begin
      if (a inside {[16'h2800:16'h2FFF]}) f = a - FOLD_VERT;
    end
    if (f inside {[PAL_BASE:16'h3FFF]}) f = PAL_BASE | (f & PAL_MASK);
    return f;
  endfunction

endpackage

// ===== src/vmap_vram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmap_vram
// single-port video memory with registered read data
// ----------------------------------------------------------------------------
module vmap_vram #(
  parameter int MEM_DEPTH = vmap_pkg::VMAP_MEM_DEPTH,
  localparam int AW = $clog2(MEM_DEPTH)
) (
  input  logic                  clk,
  input  vmap_pkg::vmap_mem_ctl_t ctl,
  input  logic [AW-1:0]         addr,
  input  logic [7:0]            wdata,
  output logic [7:0]            rdata
);
  import vmap_pkg::*;

  logic [7:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/video_memory_access_port_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_memory_access_port_core
// cpu-side access port of a 16 KB tile video memory
// ----------------------------------------------------------------------------
//   channel | signals                          | direction
//   req     | req_valid, req_stall, req        | request in
//   rsp     | rsp_valid, rsp_stall, rsp        | result out
//   cfg     | cfg_valid, cfg_ready, cfg_index, | register write in
//           | cfg_data                         |
//
// one request per cycle while req_stall is low; each result appears in the cycle after its request is accepted
// the video memory port is used at most once per request, read data registered
// req_stall is high while a result is held by rsp_stall
// synchronous reset clears address, toggle, scroll, read buffer and config;
// memory contents stay undefined until written, no clearing pass
// ----------------------------------------------------------------------------
module video_memory_access_port_core #(
  parameter int MEM_DEPTH = vmap_pkg::VMAP_MEM_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  vmap_pkg::vmap_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output vmap_pkg::vmap_rsp_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [1:0]          cfg_data
);
  import vmap_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  logic [1:0]  mirror_mode;
  logic        addr_inc_32;
  logic [15:0] access_address, access_address_next;
  logic        write_toggle, write_toggle_next;
  logic [2:0]  fine_x, fine_x_next, fine_y, fine_y_next;
  logic [4:0]  coarse_x, coarse_x_next, coarse_y, coarse_y_next;
  logic [7:0]  read_buffer;
  logic        buf_pending, buf_pending_next;
  logic [7:0]  rd, rd_next;
  logic        err, err_next;
  logic        from_mem, from_mem_next;

  logic          accept;
  logic [15:0]   folded;
  logic [7:0]    buf_eff;
  logic [7:0]    mem_q;
  logic [7:0]    wdata;
  vmap_mem_ctl_t mem_ctl;

  assign accept    = req_valid && !req_stall;
  assign req_stall = rsp_valid && rsp_stall;
  assign cfg_ready = 1'b1;
  assign folded    = vmap_fold(access_address, mirror_mode);
  assign buf_eff   = buf_pending ? mem_q : read_buffer;

  always_comb begin
    access_address_next = access_address;
    write_toggle_next   = write_toggle;
    fine_x_next         = fine_x;
    coarse_x_next       = coarse_x;
    fine_y_next         = fine_y;
    coarse_y_next       = coarse_y;
    rd_next             = '0;
    err_next            = 1'b0;
    from_mem_next       = 1'b0;
    buf_pending_next    = 1'b0;
    mem_ctl             = '0;
    wdata               = req.data_in;
    case (req.req_type)
      REQ_ADDR: begin
        if (!write_toggle) begin
          access_address_next = {req.data_in, access_address[7:0]};
        end else begin
          access_address_next = {access_address[15:8], req.data_in};
        end
        write_toggle_next = !write_toggle;
      end
      REQ_SCROLL: begin
        if (!write_toggle) begin
          fine_x_next   = 3'(req.data_in & FINE_MASK);
          coarse_x_next = req.data_in[7:3];
        end else begin
          fine_y_next   = 3'(req.data_in & FINE_MASK);
          coarse_y_next = req.data_in[7:3];
        end
        write_toggle_next = !write_toggle;
      end
      REQ_STATUS: begin
        write_toggle_next = 1'b0;
      end
      REQ_WRITE, REQ_READ: begin
        if (access_address >= UNMAPPED_BASE) begin
          err_next = 1'b1;
        end else begin
          access_address_next = access_address + (addr_inc_32 ? 16'd32 : 16'd1);
          if (req.req_type == REQ_WRITE) begin
            mem_ctl.we = accept;
            if (folded >= PAL_BASE) wdata = req.data_in & PAL_DATA_MASK;
          end else begin
            mem_ctl.re = accept;
            if (access_address <= BUFFERED_TOP) begin
              rd_next          = buf_eff;
              buf_pending_next = accept;
            end else begin
              from_mem_next = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  vmap_vram #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_vram (
    .clk  (clk),
    .ctl  (mem_ctl),
    .addr (folded[AW-1:0]),
    .wdata(wdata),
    .rdata(mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode    <= '0;
      addr_inc_32    <= 1'b0;
      access_address <= '0;
      write_toggle   <= 1'b0;
      fine_x         <= '0;
      coarse_x       <= '0;
      fine_y         <= '0;
      coarse_y       <= '0;
      read_buffer    <= '0;
      buf_pending    <= 1'b0;
      rsp_valid      <= 1'b0;
      from_mem       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MIRROR_MODE) mirror_mode <= cfg_data;
        if (cfg_index == CFG_ADDR_INC_32) addr_inc_32 <= cfg_data[0];
      end
      if (buf_pending) read_buffer <= mem_q;
      buf_pending <= buf_pending_next;
      if (accept) begin
        access_address <= access_address_next;
        write_toggle   <= write_toggle_next;
        fine_x         <= fine_x_next;
        coarse_x       <= coarse_x_next;
        fine_y         <= fine_y_next;
        coarse_y       <= coarse_y_next;
        from_mem       <= from_mem_next;
        rsp_valid      <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd  <= rd_next;
      err <= err_next;
    end
  end

  always_comb begin
    rsp.read_data       = from_mem ? mem_q : rd;
    rsp.unmapped_error  = err;
    rsp.cur_address     = access_address;
    rsp.scroll_fine_x   = fine_x;
    rsp.scroll_coarse_x = coarse_x;
    rsp.scroll_fine_y   = fine_y;
    rsp.scroll_coarse_y = coarse_y;
  end

endmodule

// ===== src/vmap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmap_checker
// port-level checks on the video memory access port
// ----------------------------------------------------------------------------
`include "video_memory_access_port_core_defines.svh"

module vmap_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input vmap_pkg::vmap_rsp_t rsp
);
  import vmap_pkg::*;

  // an error result never carries read data
  `VMAP_ASSERT_IMPLY(a_err_no_data, clk, rst, rsp_valid && rsp.unmapped_error, rsp.read_data == 8'd0, "error result with nonzero read data")

  // request side only backs up behind a held result
  `VMAP_ASSERT_IMPLY(a_stall_source, clk, rst, req_stall, rsp_valid && rsp_stall, "request stalled without a held result")

  // every accepted transaction shows a result next cycle
  `VMAP_ASSERT_NEXT(a_req_to_rsp, clk, rst, req_valid && !req_stall, rsp_valid, "accepted transaction produced no result")

  // a held result keeps its payload
  `VMAP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "held result changed")

endmodule

bind video_memory_access_port_core vmap_checker u_vmap_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);
